>>> sv/ule_pkg.sv
package ule_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_NL
  } ule_state_t;

  // One emitted character after escaping, offered to the output register
  typedef struct packed {
    logic        valid;
    logic [47:0] text;
    logic [2:0]  count;
    logic        line_done;
    logic        block_done;
  } ule_emit_t;

  typedef struct packed {
    logic [47:0] text;
    logic [2:0]  count;
  } ule_esc_t;

  localparam logic [7:0] CHAR_BIAS  = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_APOS  = 8'h27;
  localparam logic [7:0] CHAR_QUOT  = 8'h22;

  // Entity text, first character in the lowest byte
  localparam logic [47:0] ENT_LT    = 48'h00003B746C26;
  localparam logic [47:0] ENT_GT    = 48'h00003B746726;
  localparam logic [47:0] ENT_AMP   = 48'h003B706D6126;
  localparam logic [47:0] ENT_APOS  = 48'h3B3933302326;
  localparam logic [47:0] ENT_QUOT  = 48'h3B746F757126;

  function automatic ule_esc_t esc(input logic [7:0] ch);
    ule_esc_t r;
    r.text  = {40'h0, ch};
    r.count = 3'd1;
    case (ch)
      CHAR_LT: begin
        r.text  = ENT_LT;
        r.count = 3'd4;
      end
      CHAR_GT: begin
        r.text  = ENT_GT;
        r.count = 3'd4;
      end
      CHAR_AMP: begin
        r.text  = ENT_AMP;
        r.count = 3'd5;
      end
      CHAR_APOS: begin
        r.text  = ENT_APOS;
        r.count = 3'd6;
      end
      CHAR_QUOT: begin
        r.text  = ENT_QUOT;
        r.count = 3'd6;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] enc6(input logic [5:0] v);
    return {2'b00, v} + CHAR_BIAS;
  endfunction

endpackage

>>> sv/ule_ram.sv
module ule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ule_seq.sv
module ule_seq #(
  parameter int LINE_BYTES = 45
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          block_end,
  output logic                          ram_we,
  output logic [$clog2(LINE_BYTES)-1:0] ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(LINE_BYTES)-1:0] ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output ule_pkg::ule_emit_t            emit,
  input  logic                          emit_take
);
  import ule_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(LINE_BYTES + 2);
  localparam logic [CW-1:0] FULL = CW'(LINE_BYTES);

  ule_state_t    state, state_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] n, n_next;
  logic          last, last_next;
  logic [1:0]    ph, ph_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [7:0]    prev, prev_next;

  logic          accept;
  logic [CW-1:0] n_new;
  logic [CW-1:0] nidx;
  logic [7:0]    rbyte;
  logic [5:0]    code;
  logic [7:0]    ch;
  ule_esc_t      e;

  assign accept    = byte_valid && (state == ST_IDLE);
  assign n_new     = held + 1'b1;
  assign nidx      = rd_idx + 1'b1;
  assign ram_we    = accept;
  assign ram_waddr = held[AW-1:0];
  assign ram_wdata = data_byte;
  assign byte_stall = (state != ST_IDLE);

  // Bytes past the line end read as zero padding
  assign rbyte = (rd_idx < n) ? ram_rdata : 8'h00;

  always_comb begin
    case (ph)
      2'd0:    code = rbyte[7:2];
      2'd1:    code = {prev[1:0], rbyte[7:4]};
      2'd2:    code = {prev[3:0], rbyte[7:6]};
      default: code = prev[5:0];
    endcase
  end

  always_comb begin
    ch = CHAR_NL;
    if (state == ST_LEN) begin
      ch = enc6(6'(n));
    end else if (state == ST_DATA) begin
      ch = enc6(code);
    end
  end

  assign e = esc(ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      held  <= '0;
    end else begin
      state <= state_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    last   <= last_next;
    ph     <= ph_next;
    rd_idx <= rd_idx_next;
    prev   <= prev_next;
  end

  // Writes happen only in idle and reads only while a line is emitted,
  // so the two RAM ports never touch the same entry in one cycle.
  always_comb begin
    state_next  = state;
    held_next   = held;
    n_next      = n;
    last_next   = last;
    ph_next     = ph;
    rd_idx_next = rd_idx;
    prev_next   = prev;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    emit.valid      = 1'b0;
    emit.text       = e.text;
    emit.count      = e.count;
    emit.line_done  = 1'b0;
    emit.block_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (n_new == FULL || block_end) begin
            state_next = ST_LEN;
            n_next     = n_new;
            last_next  = block_end;
            held_next  = '0;
          end else begin
            held_next = n_new;
          end
        end
      end
      ST_LEN: begin
        emit.valid = 1'b1;
        if (emit_take) begin
          ram_re      = 1'b1;
          rd_idx_next = '0;
          ph_next     = 2'd0;
          state_next  = ST_DATA;
        end
      end
      ST_DATA: begin
        emit.valid = 1'b1;
        if (emit_take) begin
          prev_next = rbyte;
          ram_raddr = nidx[AW-1:0];
          case (ph) inside
            2'd0, 2'd1: begin
              ph_next     = ph + 2'd1;
              rd_idx_next = nidx;
              ram_re      = (nidx < n);
            end
            2'd2: ph_next = 2'd3;
            default: begin
              if (nidx >= n) begin
                state_next = ST_NL;
              end else begin
                ph_next     = 2'd0;
                rd_idx_next = nidx;
                ram_re      = 1'b1;
              end
            end
          endcase
        end
      end
      ST_NL: begin
        emit.valid      = 1'b1;
        emit.line_done  = 1'b1;
        emit.block_done = last;
        if (emit_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_held_below_line: assert property (@(posedge clk) disable iff (rst)
    held < FULL) else $error("line fill count reached a full line");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re) else $error("line store read during a write");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (CW'(ram_raddr) < n)) else $error("read past the line end");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && state_next == ST_LEN) |=> (held == '0))
    else $error("fill count not cleared on flush");

endmodule

>>> sv/uuencode_line_xml_escape.sv
// Channel  | Direction | Handshake               | Payload
// byte     | in        | byte_valid / byte_stall | data_byte, block_end
// text     | out       | text_valid / text_stall | text_chars, char_count,
//          |           |                         | line_done, block_done
//
// A line of n bytes is emitted as 2 + 4*ceil(n/3) items at one item per
// cycle while text_stall is low, paced by the single read port of the line
// store; bytes are held off (byte_stall high) until the newline item has
// left the sequencer. Reset clears the sequencer state and fill count and
// the output valid flag; the line store needs no clearing pass, since only
// entries written for the current line are read. text_stall only freezes
// the output register and the sequencer behind it.
module uuencode_line_xml_escape #(
  parameter int LINE_BYTES = 45
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        block_end,
  output logic        text_valid,
  input  logic        text_stall,
  output logic [47:0] text_chars,
  output logic [2:0]  char_count,
  output logic        line_done,
  output logic        block_done
);
  import ule_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  ule_emit_t     emit;
  logic          emit_take;

  ule_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ule_seq #(
    .LINE_BYTES(LINE_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .block_end  (block_end),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .emit       (emit),
    .emit_take  (emit_take)
  );

  // Load the output register when it is empty or being drained
  assign emit_take = emit.valid && (!text_valid || !text_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (emit_take) begin
      text_valid <= 1'b1;
    end else if (!text_stall) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      text_chars <= emit.text;
      char_count <= emit.count;
      line_done  <= emit.line_done;
      block_done <= emit.block_done;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (char_count != 3'd0 && char_count <= 3'd6))
    else $error("character count out of range");

  a_block_on_newline: assert property (@(posedge clk) disable iff (rst)
    (text_valid && block_done) |-> line_done)
    else $error("block end outside a newline item");

  a_newline_plain: assert property (@(posedge clk) disable iff (rst)
    (text_valid && line_done) |-> (char_count == 3'd1 && text_chars[7:0] == CHAR_NL))
    else $error("line end item is not a newline");

endmodule
